// ===== src/utf8_stream_validator_assert.svh =====
// ----------------------------------------------------------------------------
// utf8 stream validator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define UTF8V_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8v assertion failed");

// next-cycle implication
`define UTF8V_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8v assertion failed");

`endif

// ===== src/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// byte range constants and shared types for the utf8 stream validator
// ----------------------------------------------------------------------------
`default_nettype none

package utf8v_pkg;

    localparam logic [7:0] ASCII_MAX    = 8'h7f;
    localparam logic [7:0] NEWLINE      = 8'h0a;
    localparam logic [7:0] LEAD2_MIN    = 8'hc2;
    localparam logic [7:0] LEAD2_MAX    = 8'hdf;
    localparam logic [7:0] LEAD3_MIN    = 8'he0;
    localparam logic [7:0] LEAD3_MAX    = 8'hef;
    localparam logic [7:0] LEAD4_MIN    = 8'hf0;
    localparam logic [7:0] LEAD4_MAX    = 8'hf4;
    localparam logic [7:0] CONT_MIN     = 8'h80;
    localparam logic [7:0] CONT_MAX     = 8'hbf;
    localparam logic [7:0] LEAD_E0      = 8'he0;
    localparam logic [7:0] LEAD_ED      = 8'hed;
    localparam logic [7:0] LEAD_F0      = 8'hf0;
    localparam logic [7:0] LEAD_F4      = 8'hf4;
    localparam logic [7:0] E0_CONT_MIN  = 8'ha0;
    localparam logic [7:0] ED_CONT_MAX  = 8'h9f;
    localparam logic [7:0] F0_CONT_MIN  = 8'h90;
    localparam logic [7:0] F4_CONT_MAX  = 8'h8f;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // byte classification from the checker
    typedef struct packed {
        logic       lead_single;
        logic       lead_bad;
        logic [1:0] lead_len;
        logic       first_narrow;
        logic       cont_ok;
    } chk_t;

    // verdict as seen by the output register
    typedef struct packed {
        logic        well_formed;
        logic [31:0] offset;
        logic [31:0] line;
        logic [31:0] column;
    } verdict_t;

endpackage

`default_nettype wire

// ===== src/utf8v_check.sv =====
// ----------------------------------------------------------------------------
// utf8v_check
// classifies one byte as a lead or as a continuation of the open sequence
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_check (
    input  wire logic [7:0]      byte_in,
    input  wire logic [7:0]      pending_lead,
    input  wire logic            first_cont,
    output utf8v_pkg::chk_t      chk
);

    logic in_cont;
    logic narrow_ok;

    always_comb
    begin
        chk = '0;
        chk.lead_single = (byte_in <= utf8v_pkg::ASCII_MAX);
        if (byte_in >= utf8v_pkg::LEAD2_MIN && byte_in <= utf8v_pkg::LEAD2_MAX)
        begin
            chk.lead_len = 2'd1;
        end
        else if (byte_in >= utf8v_pkg::LEAD3_MIN && byte_in <= utf8v_pkg::LEAD3_MAX)
        begin
            chk.lead_len = 2'd2;
        end
        else if (byte_in >= utf8v_pkg::LEAD4_MIN && byte_in <= utf8v_pkg::LEAD4_MAX)
        begin
            chk.lead_len = 2'd3;
        end
        else
        begin
            chk.lead_len = 2'd0;
        end
        chk.lead_bad     = !chk.lead_single && (chk.lead_len == 2'd0);
        chk.first_narrow = (chk.lead_len >= 2'd2);

        in_cont = (byte_in >= utf8v_pkg::CONT_MIN) && (byte_in <= utf8v_pkg::CONT_MAX);
        unique case (pending_lead)
            utf8v_pkg::LEAD_E0: narrow_ok = (byte_in >= utf8v_pkg::E0_CONT_MIN);
            utf8v_pkg::LEAD_ED: narrow_ok = (byte_in <= utf8v_pkg::ED_CONT_MAX);
            utf8v_pkg::LEAD_F0: narrow_ok = (byte_in >= utf8v_pkg::F0_CONT_MIN);
            utf8v_pkg::LEAD_F4: narrow_ok = (byte_in <= utf8v_pkg::F4_CONT_MAX);
            default:            narrow_ok = 1'b1;
        endcase
        chk.cont_ok = in_cont && (!first_cont || narrow_ok);
    end

endmodule

`default_nettype wire

// ===== src/utf8v_track.sv =====
// ----------------------------------------------------------------------------
// utf8v_track
// sequence state, position counters and sticky first error
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_track #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              op,
    input  wire logic [7:0]        byte_in,
    output utf8v_pkg::verdict_t    verdict
);

    logic [1:0]            pending_reg, pending_next;
    logic [7:0]            lead_reg, lead_next;
    logic                  first_reg, first_next;
    logic [COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_BITS-1:0] line_count_reg, line_count_next;
    logic [COUNT_BITS-1:0] col_count_reg, col_count_next;
    logic                  err_reg, err_next;
    logic [COUNT_BITS-1:0] lead_off_reg, lead_off_next;
    logic [COUNT_BITS-1:0] lead_line_reg, lead_line_next;
    logic [COUNT_BITS-1:0] lead_col_reg, lead_col_next;

    utf8v_pkg::chk_t chk;
    logic            cp_done;
    logic [7:0]      cp_lead;

    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_ONE;
    endfunction

    utf8v_check u_check (
        .byte_in      (byte_in),
        .pending_lead (lead_reg),
        .first_cont   (first_reg),
        .chk          (chk)
    );

    // verdict seen by an end item in the current state
    always_comb
    begin
        if (err_reg || pending_reg != 2'd0)
        begin
            verdict.well_formed = 1'b0;
            verdict.offset      = 32'(lead_off_reg);
            verdict.line        = 32'(lead_line_reg);
            verdict.column      = 32'(lead_col_reg);
        end
        else
        begin
            verdict.well_formed = 1'b1;
            verdict.offset      = '0;
            verdict.line        = '0;
            verdict.column      = '0;
        end
    end

    always_comb
    begin
        pending_next    = pending_reg;
        lead_next       = lead_reg;
        first_next      = first_reg;
        byte_count_next = byte_count_reg;
        line_count_next = line_count_reg;
        col_count_next  = col_count_reg;
        err_next        = err_reg;
        lead_off_next   = lead_off_reg;
        lead_line_next  = lead_line_reg;
        lead_col_next   = lead_col_reg;
        cp_done         = 1'b0;
        cp_lead         = lead_reg;

        if (step && op == utf8v_pkg::OP_END)
        begin
            // verdict taken, restart the stream
            pending_next    = 2'd0;
            lead_next       = '0;
            first_next      = 1'b0;
            byte_count_next = '0;
            line_count_next = COUNT_ONE;
            col_count_next  = COUNT_ONE;
            err_next        = 1'b0;
            lead_off_next   = '0;
            lead_line_next  = '0;
            lead_col_next   = '0;
        end
        else if (step && !err_reg)
        begin
            byte_count_next = sat_inc(byte_count_reg);
            if (pending_reg == 2'd0)
            begin
                lead_off_next  = byte_count_reg;
                lead_line_next = line_count_reg;
                lead_col_next  = col_count_reg;
                lead_next      = byte_in;
                if (chk.lead_single)
                begin
                    cp_done = 1'b1;
                    cp_lead = byte_in;
                end
                else if (chk.lead_bad)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    pending_next = chk.lead_len;
                    first_next   = chk.first_narrow;
                end
            end
            else
            begin
                first_next = 1'b0;
                if (!chk.cont_ok)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    pending_next = pending_reg - 2'd1;
                    cp_done      = (pending_reg == 2'd1);
                end
            end

            if (cp_done)
            begin
                if (cp_lead == utf8v_pkg::NEWLINE)
                begin
                    line_count_next = sat_inc(line_count_reg);
                    col_count_next  = COUNT_ONE;
                end
                else
                begin
                    col_count_next = sat_inc(col_count_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 2'd0;
            lead_reg       <= '0;
            first_reg      <= 1'b0;
            byte_count_reg <= '0;
            line_count_reg <= COUNT_ONE;
            col_count_reg  <= COUNT_ONE;
            err_reg        <= 1'b0;
            lead_off_reg   <= '0;
            lead_line_reg  <= '0;
            lead_col_reg   <= '0;
        end
        else
        begin
            pending_reg    <= pending_next;
            lead_reg       <= lead_next;
            first_reg      <= first_next;
            byte_count_reg <= byte_count_next;
            line_count_reg <= line_count_next;
            col_count_reg  <= col_count_next;
            err_reg        <= err_next;
            lead_off_reg   <= lead_off_next;
            lead_line_reg  <= lead_line_next;
            lead_col_reg   <= lead_col_next;
        end
    end

`include "utf8_stream_validator_assert.svh"

    // an end item leaves a fresh stream behind
    `UTF8V_ASSERT_NEXT(a_restart, step && op == utf8v_pkg::OP_END,
        !err_reg && pending_reg == 2'd0 && byte_count_reg == '0
        && line_count_reg == COUNT_ONE && col_count_reg == COUNT_ONE)
    // first error holds until the end item
    `UTF8V_ASSERT_NEXT(a_err_sticky, err_reg && !(step && op == utf8v_pkg::OP_END), err_reg)
    // line and column never drop to zero while counting
    `UTF8V_ASSERT_NOW(a_pos_nonzero, 1'b1, line_count_reg != '0 && col_count_reg != '0)

endmodule

`default_nettype wire

// ===== src/utf8_stream_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator
// checks a byte stream for well-formed utf-8 and reports the first error
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   op, byte_value
//   verdict   out        verdict_valid / stall     well_formed, err_offset,
//                                                  err_line, err_column
//
// one item per cycle sustained while no end item is held by a stalled verdict:
// an item sits in the input register while the tracker updates its state, and
// an end item also loads the verdict register from the tracker's verdict
// rst_n clears sequence state, counters (line and column to 1) and both valids
// a stalled verdict only blocks end items; data items keep flowing past it
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        op,
    input  wire logic [7:0]  byte_value,
    // verdict channel
    output logic             verdict_valid,
    input  wire logic        verdict_stall,
    output logic             well_formed,
    output logic [31:0]      err_offset,
    output logic [31:0]      err_line,
    output logic [31:0]      err_column
);

    // input register
    logic       hold_valid_reg, hold_valid_next;
    logic       hold_op_reg;
    logic [7:0] hold_byte_reg;

    // result register
    logic                verdict_valid_reg, verdict_valid_next;
    utf8v_pkg::verdict_t verdict_reg;
    utf8v_pkg::verdict_t verdict_comb;

    logic out_free;
    logic advance;
    logic take_item;

    // verdict slot is free when empty or being taken this cycle
    assign out_free = !verdict_valid_reg || !verdict_stall;

    // data items always retire; end items need the verdict slot
    assign advance = hold_valid_reg && (hold_op_reg == utf8v_pkg::OP_DATA || out_free);

    assign item_stall = hold_valid_reg && !advance;
    assign take_item  = item_valid && !item_stall;

    utf8v_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .op      (hold_op_reg),
        .byte_in (hold_byte_reg),
        .verdict (verdict_comb)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (!hold_valid_reg || advance)
        begin
            hold_valid_next = item_valid;
        end

        verdict_valid_next = verdict_valid_reg && verdict_stall;
        if (advance && hold_op_reg == utf8v_pkg::OP_END)
        begin
            verdict_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg    <= 1'b0;
            verdict_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg    <= hold_valid_next;
            verdict_valid_reg <= verdict_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            hold_op_reg   <= op;
            hold_byte_reg <= byte_value;
        end
        if (advance && hold_op_reg == utf8v_pkg::OP_END)
        begin
            verdict_reg <= verdict_comb;
        end
    end

    assign verdict_valid = verdict_valid_reg;
    assign well_formed   = verdict_reg.well_formed;
    assign err_offset    = verdict_reg.offset;
    assign err_line      = verdict_reg.line;
    assign err_column    = verdict_reg.column;

`include "utf8_stream_validator_assert.svh"

    // stall only while an item is held
    `UTF8V_ASSERT_NOW(a_stall_held, item_stall, hold_valid_reg)
    // an end item that retires produces a verdict next cycle
    `UTF8V_ASSERT_NEXT(a_end_verdict, advance && hold_op_reg == utf8v_pkg::OP_END,
        verdict_valid_reg)
    // a clean verdict carries zero position fields
    `UTF8V_ASSERT_NOW(a_clean_zero, verdict_valid_reg && verdict_reg.well_formed,
        verdict_reg.offset == '0 && verdict_reg.line == '0 && verdict_reg.column == '0)

endmodule

`default_nettype wire

// ===== test/utf8_verdict_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8 verdict checker
// watches the item and verdict channels, tracks the stream state on its own
// and compares each verdict with the one its predictor worked out
// ----------------------------------------------------------------------------

module utf8_verdict_checker #(
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic        op,
    input  logic [7:0]  byte_value,
    input  logic        verdict_valid,
    input  logic        verdict_stall,
    input  logic        well_formed,
    input  logic [31:0] err_offset,
    input  logic [31:0] err_line,
    input  logic [31:0] err_column,
    output int          failures,
    output int          outstanding
);

    // predicted stream state
    logic [1:0]            conts_left;
    logic [7:0]            open_lead;
    logic                  narrow_next;
    logic                  stream_bad;
    logic [COUNT_BITS-1:0] byte_pos;
    logic [COUNT_BITS-1:0] line_no;
    logic [COUNT_BITS-1:0] col_no;
    logic [COUNT_BITS-1:0] lead_pos;
    logic [COUNT_BITS-1:0] lead_line;
    logic [COUNT_BITS-1:0] lead_col;

    utf8v_pkg::verdict_t pending_verdicts[$];

    function automatic logic [COUNT_BITS-1:0] sat_bump(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic restart_stream();
        conts_left  = '0;
        open_lead   = '0;
        narrow_next = 1'b0;
        stream_bad  = 1'b0;
        byte_pos    = '0;
        line_no     = COUNT_BITS'(1);
        col_no      = COUNT_BITS'(1);
        lead_pos    = '0;
        lead_line   = '0;
        lead_col    = '0;
    endtask

    task automatic end_code_point(input logic [7:0] lead);
        if (lead == utf8v_pkg::NEWLINE)
        begin
            line_no = sat_bump(line_no);
            col_no  = COUNT_BITS'(1);
        end
        else
            col_no = sat_bump(col_no);
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic ok;
        if (conts_left == 2'd0)
        begin
            lead_pos  = byte_pos;
            lead_line = line_no;
            lead_col  = col_no;
            open_lead = b;
            if (b <= utf8v_pkg::ASCII_MAX)
                end_code_point(b);
            else if (b >= utf8v_pkg::LEAD2_MIN && b <= utf8v_pkg::LEAD2_MAX)
            begin
                conts_left  = 2'd1;
                narrow_next = 1'b0;
            end
            else if (b >= utf8v_pkg::LEAD3_MIN && b <= utf8v_pkg::LEAD3_MAX)
            begin
                conts_left  = 2'd2;
                narrow_next = 1'b1;
            end
            else if (b >= utf8v_pkg::LEAD4_MIN && b <= utf8v_pkg::LEAD4_MAX)
            begin
                conts_left  = 2'd3;
                narrow_next = 1'b1;
            end
            else
                stream_bad = 1'b1;
        end
        else
        begin
            ok = (b >= utf8v_pkg::CONT_MIN && b <= utf8v_pkg::CONT_MAX);
            if (ok && narrow_next)
            begin
                case (open_lead)
                    utf8v_pkg::LEAD_E0: ok = (b >= utf8v_pkg::E0_CONT_MIN);
                    utf8v_pkg::LEAD_ED: ok = (b <= utf8v_pkg::ED_CONT_MAX);
                    utf8v_pkg::LEAD_F0: ok = (b >= utf8v_pkg::F0_CONT_MIN);
                    utf8v_pkg::LEAD_F4: ok = (b <= utf8v_pkg::F4_CONT_MAX);
                    default:            ok = 1'b1;
                endcase
            end
            narrow_next = 1'b0;
            if (!ok)
                stream_bad = 1'b1;
            else
            begin
                conts_left = conts_left - 2'd1;
                if (conts_left == 2'd0)
                    end_code_point(open_lead);
            end
        end
    endtask

    task automatic close_stream(output utf8v_pkg::verdict_t v);
        if (conts_left != 2'd0)
            stream_bad = 1'b1;
        if (stream_bad)
        begin
            v.well_formed = 1'b0;
            v.offset      = 32'(lead_pos);
            v.line        = 32'(lead_line);
            v.column      = 32'(lead_col);
        end
        else
            v = '{well_formed: 1'b1, offset: '0, line: '0, column: '0};
        restart_stream();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utf8v_pkg::verdict_t want;
        utf8v_pkg::verdict_t made;
        if (!rst_n)
        begin
            restart_stream();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (verdict_valid && !verdict_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("verdict arrived with none predicted");
                    failures++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("well_formed", 32'(want.well_formed), 32'(well_formed));
                    check_field("err_offset", want.offset, err_offset);
                    check_field("err_line", want.line, err_line);
                    check_field("err_column", want.column, err_column);
                end
            end
            if (item_valid && !item_stall)
            begin
                if (op == utf8v_pkg::OP_END)
                begin
                    close_stream(made);
                    pending_verdicts.push_back(made);
                end
                else if (!stream_bad)
                begin
                    take_byte(byte_value);
                    byte_pos = sat_bump(byte_pos);
                end
            end
            outstanding = pending_verdicts.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives byte streams into the utf8 stream validator, mostly well formed
// code points with random content and some broken or cut-short sequences,
// under four phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------

module tb;

    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 200000;
    // drain time after the last verdict
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        op = utf8v_pkg::OP_DATA;
    logic [7:0]  byte_value = 8'h00;
    logic        verdict_valid;
    logic        verdict_stall = 1'b0;
    logic        well_formed;
    logic [31:0] err_offset;
    logic [31:0] err_line;
    logic [31:0] err_column;

    int failures;
    int outstanding;

    // percent chance per cycle of a sender gap and of a receiver stall
    int idle_pct = 0;
    int stall_pct = 0;
    int sent = 0;
    int cycles = 0;

    // bytes of the stream being built, sent before its end item
    logic [7:0] stream_bytes[$];

    utf8_stream_validator #(
        .COUNT_BITS(32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .byte_value    (byte_value),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .well_formed   (well_formed),
        .err_offset    (err_offset),
        .err_line      (err_line),
        .err_column    (err_column)
    );

    utf8_verdict_checker #(
        .COUNT_BITS(32)
    ) verdict_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .byte_value    (byte_value),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .well_formed   (well_formed),
        .err_offset    (err_offset),
        .err_line      (err_line),
        .err_column    (err_column),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // receiver stalls change only at the falling edge
    always @(negedge clk)
    begin
        verdict_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // random byte in an inclusive range
    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // sequence length of the next code point, ascii weighted
    function automatic int code_len();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return 1;
        else if (r < 6)
            return 2;
        else if (r < 8)
            return 3;
        return 4;
    endfunction

    // one well formed code point of the given length with random content
    task automatic push_code_point(input int len);
        logic [7:0] lead;
        case (len)
            1:
            begin
                // newline often enough to move the line counter
                if ($urandom_range(3) == 0)
                    stream_bytes.push_back(utf8v_pkg::NEWLINE);
                else
                    stream_bytes.push_back(rand_byte(0, utf8v_pkg::ASCII_MAX));
            end
            2:
            begin
                stream_bytes.push_back(rand_byte(utf8v_pkg::LEAD2_MIN, utf8v_pkg::LEAD2_MAX));
                stream_bytes.push_back(rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
            end
            3:
            begin
                lead = rand_byte(utf8v_pkg::LEAD3_MIN, utf8v_pkg::LEAD3_MAX);
                stream_bytes.push_back(lead);
                // first continuation honors the narrowed bounds
                if (lead == utf8v_pkg::LEAD_E0)
                    stream_bytes.push_back(
                        rand_byte(utf8v_pkg::E0_CONT_MIN, utf8v_pkg::CONT_MAX));
                else if (lead == utf8v_pkg::LEAD_ED)
                    stream_bytes.push_back(
                        rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::ED_CONT_MAX));
                else
                    stream_bytes.push_back(
                        rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
                stream_bytes.push_back(rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
            end
            default:
            begin
                lead = rand_byte(utf8v_pkg::LEAD4_MIN, utf8v_pkg::LEAD4_MAX);
                stream_bytes.push_back(lead);
                if (lead == utf8v_pkg::LEAD_F0)
                    stream_bytes.push_back(
                        rand_byte(utf8v_pkg::F0_CONT_MIN, utf8v_pkg::CONT_MAX));
                else if (lead == utf8v_pkg::LEAD_F4)
                    stream_bytes.push_back(
                        rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::F4_CONT_MAX));
                else
                    stream_bytes.push_back(
                        rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
                stream_bytes.push_back(rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
                stream_bytes.push_back(rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
            end
        endcase
    endtask

    // one broken piece of stream; cut is set when it must be the last thing
    task automatic push_defect(output bit cut);
        logic [7:0] lead;
        int         len;
        cut = 1'b0;
        case ($urandom_range(4))
            0:
            begin
                // lead outside the allowed ranges
                case ($urandom_range(2))
                    0: stream_bytes.push_back(
                        rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
                    1: stream_bytes.push_back(
                        rand_byte(utf8v_pkg::CONT_MAX + 1, utf8v_pkg::LEAD2_MIN - 1));
                    default: stream_bytes.push_back(
                        rand_byte(utf8v_pkg::LEAD4_MAX + 1, 255));
                endcase
            end
            1:
            begin
                // first continuation just outside its narrowed bounds
                case ($urandom_range(3))
                    0:
                    begin
                        stream_bytes.push_back(utf8v_pkg::LEAD_E0);
                        stream_bytes.push_back(
                            rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::E0_CONT_MIN - 1));
                    end
                    1:
                    begin
                        stream_bytes.push_back(utf8v_pkg::LEAD_ED);
                        stream_bytes.push_back(
                            rand_byte(utf8v_pkg::ED_CONT_MAX + 1, utf8v_pkg::CONT_MAX));
                    end
                    2:
                    begin
                        stream_bytes.push_back(utf8v_pkg::LEAD_F0);
                        stream_bytes.push_back(
                            rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::F0_CONT_MIN - 1));
                    end
                    default:
                    begin
                        stream_bytes.push_back(utf8v_pkg::LEAD_F4);
                        stream_bytes.push_back(
                            rand_byte(utf8v_pkg::F4_CONT_MAX + 1, utf8v_pkg::CONT_MAX));
                    end
                endcase
            end
            2:
            begin
                // non-continuation byte where a continuation belongs
                lead = rand_byte(utf8v_pkg::LEAD2_MIN, utf8v_pkg::LEAD4_MAX);
                stream_bytes.push_back(lead);
                if (lead >= utf8v_pkg::LEAD3_MIN && lead != utf8v_pkg::LEAD_E0
                        && lead != utf8v_pkg::LEAD_ED && lead != utf8v_pkg::LEAD_F0
                        && lead != utf8v_pkg::LEAD_F4 && $urandom_range(1) == 1)
                    stream_bytes.push_back(
                        rand_byte(utf8v_pkg::CONT_MIN, utf8v_pkg::CONT_MAX));
                if ($urandom_range(1) == 0)
                    stream_bytes.push_back(rand_byte(0, utf8v_pkg::CONT_MIN - 1));
                else
                    stream_bytes.push_back(rand_byte(utf8v_pkg::CONT_MAX + 1, 255));
            end
            3:
            begin
                // sequence cut short by the end item
                len = $urandom_range(4, 2);
                push_code_point(len);
                repeat ($urandom_range(len - 1, 1))
                    void'(stream_bytes.pop_back());
                cut = 1'b1;
            end
            default:
            begin
                // raw noise, may or may not be well formed
                repeat ($urandom_range(6, 1))
                    stream_bytes.push_back(rand_byte(0, 255));
            end
        endcase
    endtask

    // one item on the channel, random gaps before it, held until taken
    task automatic send_item(input logic item_op, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        op         = item_op;
        byte_value = b;
        do
            @(posedge clk);
        while (item_stall);
        sent++;
    endtask

    // send the built stream and close it with an end item
    task automatic flush_stream();
        foreach (stream_bytes[i])
            send_item(utf8v_pkg::OP_DATA, stream_bytes[i]);
        stream_bytes.delete();
        // byte field is don't-care on an end item, randomize it anyway
        send_item(utf8v_pkg::OP_END, rand_byte(0, 255));
    endtask

    initial
    begin
        bit cut;
        int phase;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty stream
        flush_stream();

        // ascii extremes, newline, two-byte extremes
        stream_bytes = '{8'h00, utf8v_pkg::ASCII_MAX, utf8v_pkg::NEWLINE,
                         utf8v_pkg::LEAD2_MIN, utf8v_pkg::CONT_MIN,
                         utf8v_pkg::LEAD2_MAX, utf8v_pkg::CONT_MAX};
        flush_stream();

        // narrowed leads at the edges of their allowed continuation
        stream_bytes = '{utf8v_pkg::LEAD_E0, utf8v_pkg::E0_CONT_MIN, utf8v_pkg::CONT_MIN,
                         utf8v_pkg::LEAD_ED, utf8v_pkg::ED_CONT_MAX, utf8v_pkg::CONT_MAX,
                         utf8v_pkg::LEAD_F4, utf8v_pkg::F4_CONT_MAX, utf8v_pkg::CONT_MAX,
                         utf8v_pkg::CONT_MAX};
        flush_stream();

        // narrowed bound broken after e0, then a byte that must be ignored
        stream_bytes = '{utf8v_pkg::LEAD_E0, utf8v_pkg::E0_CONT_MIN - 8'd1, 8'hff};
        flush_stream();

        // four-byte lead cut short by the end item
        stream_bytes = '{utf8v_pkg::LEAD_F0};
        flush_stream();

        // random streams over four idling phases
        while (sent < ITEM_TARGET)
        begin
            phase = sent * 4 / ITEM_TARGET;
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    idle_pct  = 9;
                    stall_pct = 9;
                end
            endcase
            repeat ($urandom_range(14, 0))
                push_code_point(code_len());
            if ($urandom_range(9) < 3)
            begin
                push_defect(cut);
                // trailing bytes after a defect exercise the sticky error
                if (!cut)
                    repeat ($urandom_range(4, 0))
                        push_code_point(code_len());
            end
            flush_stream();
        end

        @(negedge clk);
        item_valid = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;

        // wait out every predicted verdict, then a short drain
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/utf8v_pkg.sv
src/utf8v_check.sv
src/utf8v_track.sv
src/utf8_stream_validator.sv
test/utf8_verdict_checker.sv
test/tb.sv
